### rtl/core/wwtm_pkg.sv
// wwtm_pkg: shared types and constants of the whole-word text matcher
// used by every module under rtl/core; depends on nothing else
package wwtm_pkg;

    // sizes of the search
    localparam int NEEDLE_BYTES  = 32;
    localparam int NEEDLE_IDX_W  = $clog2(NEEDLE_BYTES);
    localparam int NEEDLE_WORDS  = 4;
    localparam int MAX_MATCHES   = 4096;
    localparam int TEXT_LIMIT    = 16777216;

    // field widths
    localparam int LEN_W    = 6;
    localparam int START_W  = 24;
    localparam int END_W    = 25;
    localparam int TOTAL_W  = 13;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;

    // results one item can cause, and the result queue depth
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEEDLE_0      = 3'd0,
        REG_NEEDLE_1      = 3'd1,
        REG_NEEDLE_2      = 3'd2,
        REG_NEEDLE_3      = 3'd3,
        REG_NEEDLE_LENGTH = 3'd4,
        REG_MATCH_CASE    = 3'd5,
        REG_WHOLE_WORD    = 3'd6
    } reg_index_t;

    // result kinds
    typedef enum logic {
        KIND_MATCH   = 1'b0,
        KIND_CLOSING = 1'b1
    } result_kind_t;

    // configuration as seen by the search stage
    typedef struct packed {
        logic [NEEDLE_BYTES-1:0][7:0] needle;
        logic [LEN_W-1:0]             needle_length;
        logic                         match_case;
        logic                         whole_word;
    } cfg_t;

    // one result item
    typedef struct packed {
        result_kind_t       kind;
        logic [START_W-1:0] match_start;
        logic [END_W-1:0]   match_end;
        logic [TOTAL_W-1:0] match_total;
        logic               truncated;
        logic               last_in_run;
    } result_t;

    // results of one item, packed from slot 0, handed to the queue
    typedef struct packed {
        logic [1:0]                  count;
        result_t [MAX_RESULTS-1:0]   res;
    } push_t;

endpackage

### rtl/core/whole_word_text_matcher.sv
// whole_word_text_matcher: top level of the streaming needle search
// depends on wwtm_pkg, wwtm_cfg, wwtm_search and wwtm_outq
//
// Takes one text byte per cycle and reports each leftmost, non-overlapping
// occurrence of a needle of up to 32 bytes, with optional ASCII case folding
// and an optional whole-word rule. A match is reported when the byte after it
// arrives (or on the end-of-text byte, which also yields a closing report with
// the match count). A byte sits in the input register while the full
// 32-byte window compare runs, and its results, none to three, enter a four-entry
// queue that drains one result per cycle while m_tready is high, so a first result
// passes through the input register and a queue entry before it can leave.
// Input is taken every cycle while the queue holds at most one result; an item
// that causes three results needs three output transfers. The user must write
// configuration only while no text is in flight; the block does not enforce it.
module whole_word_text_matcher (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wwtm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wwtm_pkg::CFG_W-1:0]     cfg_data,
    // text input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] text_byte
    input  logic                           s_tlast,   // end_of_text
    // result output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_tdata,   // [23:0] match_start, [48:24] match_end,
                                                      // [61:49] match_total, [62] truncated,
                                                      // [63] zero
    output logic                           m_tuser,   // result_kind
    output logic                           m_tlast    // last_in_run
);
    import wwtm_pkg::*;

    cfg_t    cfg;
    push_t   push;
    logic    room;
    result_t out_item;

    // configuration registers
    wwtm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // search stage
    wwtm_search u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .queue_room (room),
        .push       (push)
    );

    // result queue
    wwtm_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    // output packing
    assign m_tdata = {1'b0, out_item.truncated, out_item.match_total,
                      out_item.match_end, out_item.match_start};
    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.last_in_run;

endmodule

### rtl/core/wwtm_cfg.sv
// wwtm_cfg: configuration registers of the whole-word text matcher
// depends on wwtm_pkg
module wwtm_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wwtm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wwtm_pkg::CFG_W-1:0]       cfg_data,
    output wwtm_pkg::cfg_t                   cfg
);
    import wwtm_pkg::*;

    logic [NEEDLE_WORDS-1:0][CFG_W-1:0] needle_reg;
    logic [LEN_W-1:0]                   length_reg;
    logic                               match_case_reg;
    logic                               whole_word_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_reg     <= '0;
            length_reg     <= '0;
            match_case_reg <= 1'b0;
            whole_word_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_NEEDLE_0:      needle_reg[0]  <= cfg_data;
                REG_NEEDLE_1:      needle_reg[1]  <= cfg_data;
                REG_NEEDLE_2:      needle_reg[2]  <= cfg_data;
                REG_NEEDLE_3:      needle_reg[3]  <= cfg_data;
                REG_NEEDLE_LENGTH: length_reg     <= cfg_data[LEN_W-1:0];
                REG_MATCH_CASE:    match_case_reg <= cfg_data[0];
                REG_WHOLE_WORD:    whole_word_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // byte 0 of the needle sits in the low bits of word 0
    assign cfg.needle        = needle_reg;
    assign cfg.needle_length = length_reg;
    assign cfg.match_case    = match_case_reg;
    assign cfg.whole_word    = whole_word_reg;

endmodule

### rtl/core/wwtm_search.sv
// wwtm_search: input register, window compare and per-text match state
// depends on wwtm_pkg; feeds up to three results per item to the queue
module wwtm_search (
    input  logic           clk,
    input  logic           rst_n,
    input  wwtm_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    input  logic           queue_room,
    output wwtm_pkg::push_t push
);
    import wwtm_pkg::*;

    // input register
    logic       hold_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // per-text state
    logic [NEEDLE_BYTES-1:0][7:0] window_reg;
    logic [END_W-1:0]   pos_reg,   pos_next;
    logic [END_W-1:0]   pme_reg,   pme_next;
    logic [START_W-1:0] ps_reg,    ps_next;
    logic               pv_reg,    pv_next;
    logic [TOTAL_W-1:0] mf_reg,    mf_next;
    logic               cap_reg,   cap_next;
    logic               shift;

    logic                              fire;
    logic [LEN_W-1:0]                  len;
    logic [NEEDLE_BYTES-1:0][7:0]      win_new;
    logic [NEEDLE_BYTES-1:0]           byte_ok;
    logic                              body_ok;
    logic [7:0]                        before_byte;
    logic [LEN_W-1:0]                  len_m1;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic exact);
        if (!exact && c >= 8'h41 && c <= 8'h5A)
            return c + 8'd32;
        return c;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == 8'h5F || c[7];
    endfunction

    assign fire     = hold_reg && queue_room;
    assign in_ready = !hold_reg || fire;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= 1'b0;
        else if (in_ready)
            hold_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
    end

    // needle length clamped to the window
    assign len    = (cfg.needle_length > LEN_W'(NEEDLE_BYTES)) ?
                    LEN_W'(NEEDLE_BYTES) : cfg.needle_length;
    assign len_m1 = len - LEN_W'(1);

    // window with the new byte in front, compared against the needle reversed
    always_comb
    begin
        logic [LEN_W-1:0] nidx;
        win_new[0] = byte_reg;
        for (int j = 1; j < NEEDLE_BYTES; j++)
            win_new[j] = window_reg[j-1];
        for (int j = 0; j < NEEDLE_BYTES; j++)
        begin
            nidx = len_m1 - LEN_W'(j);
            if (LEN_W'(j) >= len)
                byte_ok[j] = 1'b1;
            else
                byte_ok[j] = fold(win_new[j], cfg.match_case) ==
                             fold(cfg.needle[nidx[NEEDLE_IDX_W-1:0]], cfg.match_case);
        end
    end

    assign body_ok     = &byte_ok;
    // byte just ahead of a candidate
    assign before_byte = window_reg[len_m1[NEEDLE_IDX_W-1:0]];

    // next state and results for the item in the input register
    always_comb
    begin
        logic [END_W-1:0] s;
        logic [1:0]       cnt;
        pos_next = pos_reg;
        pme_next = pme_reg;
        ps_next  = ps_reg;
        pv_next  = pv_reg;
        mf_next  = mf_reg;
        cap_next = cap_reg;
        shift    = 1'b0;
        cnt      = 2'd0;
        s        = '0;
        push.res = '0;

        if (pos_reg >= END_W'(TEXT_LIMIT))
        begin
            cap_next = 1'b1;
            pv_next  = 1'b0;
        end
        else
        begin
            shift = 1'b1;
            // confirm the candidate left by the previous byte
            if (pv_reg)
            begin
                pv_next = 1'b0;
                if ((!cfg.whole_word || !is_word(byte_reg)) && !cap_next)
                begin
                    if (mf_next >= TOTAL_W'(MAX_MATCHES))
                        cap_next = 1'b1;
                    else
                    begin
                        mf_next  = mf_next + TOTAL_W'(1);
                        pme_next = pos_reg;
                        push.res[cnt].kind        = KIND_MATCH;
                        push.res[cnt].match_start = ps_reg;
                        push.res[cnt].match_end   = pos_reg;
                        push.res[cnt].match_total = mf_next;
                        push.res[cnt].truncated   = cap_next;
                        cnt = cnt + 2'd1;
                    end
                end
            end
            // new candidate ending at this byte
            if (!cap_next && len != '0 && (pos_reg + END_W'(1)) >= END_W'(len))
            begin
                s = pos_reg + END_W'(1) - END_W'(len);
                if (s >= pme_next && body_ok &&
                    !(cfg.whole_word && s != '0 && is_word(before_byte)))
                begin
                    ps_next = s[START_W-1:0];
                    pv_next = 1'b1;
                end
            end
            pos_next = pos_reg + END_W'(1);
        end

        if (last_reg)
        begin
            // end of text confirms a candidate at once
            if (pv_next)
            begin
                pv_next = 1'b0;
                if (!cap_next)
                begin
                    if (mf_next >= TOTAL_W'(MAX_MATCHES))
                        cap_next = 1'b1;
                    else
                    begin
                        mf_next  = mf_next + TOTAL_W'(1);
                        pme_next = {1'b0, ps_next} + END_W'(len);
                        push.res[cnt].kind        = KIND_MATCH;
                        push.res[cnt].match_start = ps_next;
                        push.res[cnt].match_end   = {1'b0, ps_next} + END_W'(len);
                        push.res[cnt].match_total = mf_next;
                        push.res[cnt].truncated   = cap_next;
                        cnt = cnt + 2'd1;
                    end
                end
            end
            // closing report
            push.res[cnt].kind        = KIND_CLOSING;
            push.res[cnt].match_start = '0;
            push.res[cnt].match_end   = '0;
            push.res[cnt].match_total = mf_next;
            push.res[cnt].truncated   = cap_next;
            cnt = cnt + 2'd1;
            pos_next = '0;
            pme_next = '0;
            ps_next  = '0;
            pv_next  = 1'b0;
            mf_next  = '0;
            cap_next = 1'b0;
        end

        // mark the last result of this item
        for (int k = 0; k < MAX_RESULTS; k++)
            push.res[k].last_in_run = (2'(k + 1) == cnt);

        push.count = fire ? cnt : 2'd0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            pos_reg    <= '0;
            pme_reg    <= '0;
            ps_reg     <= '0;
            pv_reg     <= 1'b0;
            mf_reg     <= '0;
            cap_reg    <= 1'b0;
        end
        else if (fire)
        begin
            if (shift)
                window_reg <= win_new;
            pos_reg <= pos_next;
            pme_reg <= pme_next;
            ps_reg  <= ps_next;
            pv_reg  <= pv_next;
            mf_reg  <= mf_next;
            cap_reg <= cap_next;
        end
    end

endmodule

### rtl/core/wwtm_outq.sv
// wwtm_outq: four-entry result queue, up to three writes and one read a cycle
// depends on wwtm_pkg
module wwtm_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  wwtm_pkg::push_t   push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output wwtm_pkg::result_t out_item
);
    import wwtm_pkg::*;

    result_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] head_reg, head_next;
    logic [QUEUE_IDX_W-1:0] tail_reg, tail_next;
    logic [QUEUE_IDX_W:0]   count_reg, count_next;
    logic                   pop;

    assign out_valid = count_reg != '0;
    assign out_item  = entry_reg[head_reg];
    assign pop       = out_valid && out_ready;
    // a full item's worth of results always fits
    assign room      = count_reg <= (QUEUE_IDX_W + 1)'(QUEUE_DEPTH - MAX_RESULTS);

    // pointer and fill update
    always_comb
    begin
        head_next  = head_reg + QUEUE_IDX_W'(pop);
        tail_next  = tail_reg + QUEUE_IDX_W'(push.count);
        count_next = count_reg + (QUEUE_IDX_W + 1)'(push.count)
                     - (QUEUE_IDX_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (2'(k) < push.count)
                entry_reg[tail_reg + QUEUE_IDX_W'(k)] <= push.res[k];
        end
    end

endmodule
